// ===== rtl/sorted_set_membership_defines.svh =====
// assertion macros for the sorted set membership block
// used by rtl/sorted_set_membership.sv, no other dependencies
`ifndef SORTED_SET_MEMBERSHIP_DEFINES_SVH
`define SORTED_SET_MEMBERSHIP_DEFINES_SVH

// property checked on every rising clock edge, off while reset is asserted
`define SSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising clock edge, off while reset is asserted
`define SSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ssm_pkg.sv =====
// shared types and constants of the sorted set membership block
// no dependencies
`timescale 1ns / 1ps

package ssm_pkg;

  localparam int unsigned DefaultDepth = 256;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned CountW       = 9;

  typedef enum logic [1:0] {
    OpClear  = 2'd0,
    OpInsert = 2'd1,
    OpQuery  = 2'd2
  } op_e;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [CountW-1:0]        count_field_t;

endpackage

// ===== rtl/ssm_req_if.sv =====
// request and response channel interfaces of the sorted set membership block
// depends on ssm_pkg
`timescale 1ns / 1ps

interface ssm_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  ssm_pkg::value_t   value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface ssm_rsp_if;
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic                  rejected;
  ssm_pkg::count_field_t stored_count;

  modport source (output valid, output found, output rejected, output stored_count,
                  input ready);
  modport sink   (input valid, input found, input rejected, input stored_count,
                  output ready);
endinterface

// ===== rtl/sorted_set_membership.sv =====
// Sorted set membership store: keeps up to Depth signed 32-bit values in ascending
// order in one synchronous memory and handles one request at a time. Clear and an
// unused operation code are answered from idle without a memory access, as is an
// insert into a full store. A query runs a binary search that reads one memory
// entry per step. An insert moves each held value above its sorted position up one
// place with a read and a write through the single memory port pair, then writes
// the new value. A response waits in an output register; a new request is taken
// once that register is free or being emptied.
// depends on ssm_pkg, ssm_req_if.sv, ssm_value_ram.sv, sorted_set_membership_defines.svh
`timescale 1ns / 1ps
`include "sorted_set_membership_defines.svh"

module sorted_set_membership #(
  parameter int unsigned Depth = ssm_pkg::DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssm_req_if.sink   req_i,
  ssm_rsp_if.source rsp_o
);
  import ssm_pkg::*;

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSrch = 3'd1;
  localparam logic [2:0] StCmp  = 3'd2;
  localparam logic [2:0] StShRd = 3'd3;
  localparam logic [2:0] StShWr = 3'd4;
  localparam logic [2:0] StPut  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, mid_calc, count_inc;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic             hit_q, hit_d, ins_q, ins_d;
  value_t           key_q, key_d;

  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d, out_rej_q, out_rej_d;
  count_field_t     out_cnt_q, out_cnt_d;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  value_t           ram_wdata, ram_rdata;

  logic             out_free, take;

  ssm_value_ram #(.Depth(Depth), .AddrW(AddrW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free     = !out_valid_q || rsp_o.ready;
  assign req_i.ready  = (state_q == StIdle) && out_free;
  assign take         = req_i.valid && req_i.ready;
  assign mid_calc     = lo_q + ((hi_q - lo_q) >> 1);
  assign count_inc    = count_q + CntW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    ptr_d       = ptr_q;
    hit_d       = hit_q;
    ins_d       = ins_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_found_d = out_found_q;
    out_rej_d   = out_rej_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = key_q;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;

    unique case (state_q)
      StIdle: begin
        if (take) begin
          unique case (req_i.operation)
            OpClear: begin
              count_d     = '0;
              out_valid_d = 1'b1;
              out_found_d = 1'b0;
              out_rej_d   = 1'b0;
              out_cnt_d   = '0;
            end
            OpInsert, OpQuery: begin
              if ((req_i.operation == OpInsert) && (count_q >= CntW'(Depth))) begin
                out_valid_d = 1'b1;
                out_found_d = 1'b0;
                out_rej_d   = 1'b1;
                out_cnt_d   = CountW'(count_q);
              end else begin
                key_d   = req_i.value;
                ins_d   = (req_i.operation == OpInsert);
                lo_d    = '0;
                hi_d    = count_q;
                hit_d   = 1'b0;
                state_d = StSrch;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              out_found_d = 1'b0;
              out_rej_d   = 1'b0;
              out_cnt_d   = CountW'(count_q);
            end
          endcase
        end
      end
      StSrch: begin
        if (lo_q < hi_q) begin
          ram_re    = 1'b1;
          ram_raddr = mid_calc[AddrW-1:0];
          mid_d     = mid_calc;
          state_d   = StCmp;
        end else if (!ins_q) begin
          out_valid_d = 1'b1;
          out_found_d = hit_q;
          out_rej_d   = 1'b0;
          out_cnt_d   = CountW'(count_q);
          state_d     = StIdle;
        end else if (lo_q == count_q) begin
          state_d = StPut;
        end else begin
          // move entries above the insert position up by one, top first
          ptr_d   = AddrW'(count_q - CntW'(1));
          state_d = StShRd;
        end
      end
      StCmp: begin
        if (ram_rdata <= key_q) begin
          lo_d  = mid_q + CntW'(1);
          hit_d = (ram_rdata == key_q);
        end else begin
          hi_d = mid_q;
        end
        state_d = StSrch;
      end
      StShRd: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q;
        state_d   = StShWr;
      end
      StShWr: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q + AddrW'(1);
        ram_wdata = ram_rdata;
        if (CntW'(ptr_q) == lo_q) begin
          state_d = StPut;
        end else begin
          ptr_d   = ptr_q - AddrW'(1);
          state_d = StShRd;
        end
      end
      StPut: begin
        ram_we      = 1'b1;
        ram_waddr   = lo_q[AddrW-1:0];
        ram_wdata   = key_q;
        count_d     = count_inc;
        out_valid_d = 1'b1;
        out_found_d = 1'b0;
        out_rej_d   = 1'b0;
        out_cnt_d   = CountW'(count_inc);
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    ptr_q       <= ptr_d;
    hit_q       <= hit_d;
    ins_q       <= ins_d;
    key_q       <= key_d;
    out_found_q <= out_found_d;
    out_rej_q   <= out_rej_d;
    out_cnt_q   <= out_cnt_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.found        = out_found_q;
  assign rsp_o.rejected     = out_rej_q;
  assign rsp_o.stored_count = out_cnt_q;

  `SSM_ASSERT(a_count_bound, count_q <= CntW'(Depth), "count exceeds depth")
  `SSM_ASSERT_IMP(a_busy_no_rsp, state_q != StIdle, !out_valid_q,
                  "response pending while a request is in work")
  `SSM_ASSERT_IMP(a_shift_in_range, (state_q == StShRd) || (state_q == StShWr),
                  (CntW'(ptr_q) < count_q) && (CntW'(ptr_q) >= lo_q),
                  "shift pointer outside held range")
  `SSM_ASSERT_IMP(a_count_moves, count_q != $past(count_q),
                  ($past(state_q) == StPut) || $past(take),
                  "count changed outside clear or insert")

endmodule

// ===== rtl/ssm_value_ram.sv =====
// single port write, single port read value memory with registered read data
// depends on ssm_pkg
`timescale 1ns / 1ps

module ssm_value_ram #(
  parameter int unsigned Depth = ssm_pkg::DefaultDepth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  ssm_pkg::value_t       wdata_i,
  input  logic                  re_i,
  input  logic [AddrW-1:0]      raddr_i,
  output ssm_pkg::value_t       rdata_o
);
  import ssm_pkg::*;

  value_t mem_q [Depth];
  value_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sorted_set_membership_scoreboard.sv =====
// scoreboard of the sorted set membership block: tracks the held values,
// predicts each response and compares it with what the block returns
// depends on ssm_pkg and rtl/ssm_req_if.sv
`timescale 1ns / 1ps

module sorted_set_membership_scoreboard #(
  parameter int unsigned Depth = ssm_pkg::DefaultDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  ssm_req_if   req_i,
  ssm_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  import ssm_pkg::*;

  typedef struct packed {
    logic         found;
    logic         rejected;
    count_field_t stored_count;
  } membership_answer_t;

  int                 held_values[$];
  membership_answer_t answer_queue[$];
  int                 fail_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = answer_queue.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // model one request against the held values and return its answer
  function automatic membership_answer_t predict_answer(input logic [1:0] op,
                                                        input int val);
    membership_answer_t ans;
    int                 pos;
    ans = '0;
    case (op)
      OpClear: held_values.delete();
      OpInsert: begin
        if (held_values.size() >= Depth) begin
          ans.rejected = 1'b1;
        end else begin
          // lands after any equal values
          pos = 0;
          while (pos < held_values.size() && held_values[pos] <= val) pos++;
          held_values.insert(pos, val);
        end
      end
      OpQuery: begin
        foreach (held_values[k]) if (held_values[k] == val) ans.found = 1'b1;
      end
      default: ;
    endcase
    ans.stored_count = count_field_t'(held_values.size());
    return ans;
  endfunction

  always @(posedge clk_i) begin
    membership_answer_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready)
        answer_queue.push_back(predict_answer(req_i.operation, int'($signed(req_i.value))));
      if (rsp_i.valid && rsp_i.ready) begin
        if (answer_queue.size() == 0) begin
          report_mismatch("unexpected response, count", rsp_i.stored_count, -1);
        end else begin
          want = answer_queue.pop_front();
          if (rsp_i.found !== want.found)
            report_mismatch("found", rsp_i.found, want.found);
          if (rsp_i.rejected !== want.rejected)
            report_mismatch("rejected", rsp_i.rejected, want.rejected);
          if (rsp_i.stored_count !== want.stored_count)
            report_mismatch("stored_count", rsp_i.stored_count, want.stored_count);
        end
      end
    end
  end

endmodule

// ===== tb/sorted_set_membership_tb.sv =====
// testbench top of the sorted set membership block: drives requests with random
// gaps and response back-pressure, the scoreboard checks every response
// depends on ssm_pkg, rtl/ssm_req_if.sv, rtl/sorted_set_membership.sv, the scoreboard
`timescale 1ns / 1ps

module sorted_set_membership_tb;
  import ssm_pkg::*;

  localparam int unsigned Depth      = DefaultDepth;
  localparam int          ItemTarget = 1900;
  localparam int          CycleLimit = 10000000;
  localparam logic [1:0]  OpUnused   = 2'd3;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   sent_count = 0;
  int   cycle_count = 0;
  bit   no_idle = 0;
  int   full_fills = 0;

  ssm_req_if req_if ();
  ssm_rsp_if rsp_if ();

  sorted_set_membership #(.Depth(Depth)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  sorted_set_membership_scoreboard #(.Depth(Depth)) i_scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  function automatic int pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return $urandom_range(16) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [1:0] op, input int val);
    int g;
    g = pick_gap();
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.value     <= val;
    do @(posedge clk_i); while (!req_if.ready);
    sent_count++;
  endtask

  // well-formed run: clear, then inserts mixed with queries of held and random values
  task automatic run_fill_sequence(input int n_inserts);
    int inserted[$];
    int v;
    send_request(OpClear, $urandom);
    for (int k = 0; k < n_inserts; k++) begin
      v = pick_value();
      send_request(OpInsert, v);
      inserted.push_back(v);
      if ($urandom_range(3) == 0) begin
        if ($urandom_range(1)) send_request(OpQuery, inserted[$urandom_range(inserted.size() - 1)]);
        else send_request(OpQuery, pick_value());
      end
    end
    send_request(OpQuery, inserted[$urandom_range(inserted.size() - 1)]);
    send_request(OpQuery, pick_value() + 1);
  endtask

  // response side: random stalls, with one long hold-off to back up the block
  initial begin
    int r;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    for (int c = 0; ; c++) begin
      @(posedge clk_i);
      if (c == 3000) begin
        rsp_if.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      r = $urandom_range(99);
      if (no_idle || r < 70) begin
        rsp_if.ready <= 1'b1;
      end else if (r < 95) begin
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(40, 2)) @(posedge clk_i);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    req_if.valid     = 1'b0;
    req_if.operation = OpClear;
    req_if.value     = '0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed part
    send_request(OpQuery, 0);
    send_request(OpInsert, 32'h8000_0000);
    send_request(OpInsert, 32'h7fff_ffff);
    send_request(OpInsert, 0);
    send_request(OpInsert, -1);
    send_request(OpInsert, 0);
    send_request(OpQuery, 32'h8000_0000);
    send_request(OpQuery, 32'h7fff_ffff);
    send_request(OpQuery, 0);
    send_request(OpQuery, -1);
    send_request(OpQuery, 1);
    send_request(OpQuery, 32'h7fff_fffe);
    send_request(OpUnused, 32'h5555_aaaa);
    send_request(OpUnused, 32'haaaa_5555);
    send_request(OpClear, 32'hffff_ffff);
    send_request(OpQuery, 0);
    send_request(OpInsert, 7);
    send_request(OpClear, 0);

    // random part
    while (sent_count < ItemTarget) begin
      no_idle = ($urandom_range(5) == 0);
      kind = $urandom_range(99);
      if (kind < 15) begin
        repeat ($urandom_range(6, 1))
          send_request(2'($urandom_range(3)), $urandom);
      end else if (kind < 18 && full_fills < 3) begin
        // overfill to hit the rejected-insert case
        full_fills++;
        run_fill_sequence(Depth + $urandom_range(4, 1));
        send_request(OpUnused, $urandom);
        send_request(OpQuery, pick_value());
      end else begin
        run_fill_sequence($urandom_range(30, 1));
      end
    end
    no_idle = 0;
    req_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
